// ----- rtl/cmt_pkg.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer package
// Shared types, codes and constants of the compare-match timer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmt_pkg;

  localparam int unsigned DATA_W   = 64;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned VFREQ_W  = 32;
  localparam int unsigned CTRL_W   = 3;
  localparam int unsigned ACC_W    = 96;
  localparam int unsigned DIV_CNT_W = 7;
  localparam int unsigned PADDR_W  = 4;

  localparam int unsigned CTRL_ENABLE   = 0;
  localparam int unsigned CTRL_PERIODIC = 1;
  localparam int unsigned CTRL_IRQ_EN   = 2;

  localparam logic [DATA_W-1:0]  HFREQ_RESET = 64'd1000000000;
  localparam logic [VFREQ_W-1:0] VFREQ_RESET = 32'd1000000;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [SEL_W-1:0] {
    REG_CTRL    = 3'd0,
    REG_COUNT   = 3'd1,
    REG_COMPARE = 3'd2,
    REG_STATUS  = 3'd3,
    REG_FREQ    = 3'd4
  } reg_sel_e;

  typedef enum logic {
    CFG_HFREQ = 1'b0,
    CFG_VFREQ = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MUL0,
    ST_MUL1,
    ST_ACC,
    ST_DIV,
    ST_ADD,
    ST_UPD,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic latch;
    logic decode;
    logic mul0;
    logic mul1;
    logic acc;
    logic div_step;
    logic add;
    logic upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic tick_go;
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/cmt_if.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer channels
// Valid/ready channels for input items and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface cmt_item_if
  import cmt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SEL_W-1:0]  reg_select;
  logic [DATA_W-1:0] write_value;
  logic [DATA_W-1:0] host_time;

  modport source (output valid, mode, reg_select, write_value, host_time, input ready);
  modport sink   (input valid, mode, reg_select, write_value, host_time, output ready);
endinterface

interface cmt_result_if
  import cmt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              irq_raise;

  modport source (output valid, read_data, irq_raise, input ready);
  modport sink   (input valid, read_data, irq_raise, output ready);
endinterface

`default_nettype wire

// ----- rtl/cmt_apb.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer configuration registers
// APB-style access to the host and virtual frequency registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_apb
  import cmt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready,
  output logic      [DATA_W-1:0]  hfreq_o,
  output logic      [VFREQ_W-1:0] vfreq_o
);

  logic [DATA_W-1:0]  hfreq_q;
  logic [VFREQ_W-1:0] vfreq_q;
  logic               wr_en;
  cfg_reg_e           cfg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[PADDR_W-1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hfreq_q <= HFREQ_RESET;
      vfreq_q <= VFREQ_RESET;
    end else if (wr_en) begin
      case (cfg_sel)
        CFG_HFREQ: hfreq_q <= pwdata;
        CFG_VFREQ: vfreq_q <= pwdata[VFREQ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      CFG_HFREQ: prdata = hfreq_q;
      CFG_VFREQ: prdata = {{(DATA_W-VFREQ_W){1'b0}}, vfreq_q};
      default:   prdata = '0;
    endcase
  end

  assign hfreq_o = hfreq_q;
  assign vfreq_o = vfreq_q;

endmodule

`default_nettype wire

// ----- rtl/cmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer controller
// Sequences decode, multiply, iterative division and count update.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_ctrl
  import cmt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = status_i.tick_go ? ST_MUL0 : ST_DONE;
      end
      ST_MUL0: begin
        cmd_o.mul0 = 1'b1;
        state_d    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/cmt_dp.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer datapath
// Timer registers, split multiplier, radix-2 divider and compare logic.
// ----------------------------------------------------------------------------
`default_nettype none

module cmt_dp
  import cmt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire logic [MODE_W-1:0]   mode_i,
  input  wire logic [SEL_W-1:0]    reg_select_i,
  input  wire logic [DATA_W-1:0]   write_value_i,
  input  wire logic [DATA_W-1:0]   host_time_i,
  input  wire logic [DATA_W-1:0]   hfreq_i,
  input  wire logic [VFREQ_W-1:0]  vfreq_i,
  output logic      [DATA_W-1:0]   read_data_o,
  output logic                     irq_raise_o
);

  localparam int unsigned HALF_W = DATA_W / 2;

  // Latched item.
  logic [MODE_W-1:0] mode_q;
  logic [SEL_W-1:0]  sel_q;
  logic [DATA_W-1:0] wval_q;
  logic [DATA_W-1:0] htime_q;

  // Architectural state.
  logic [CTRL_W-1:0]      ctrl_q;
  logic [COUNT_WIDTH-1:0] count_q;
  logic [COUNT_WIDTH-1:0] compare_q;
  logic                   irq_status_q;
  logic [DATA_W-1:0]      last_q;
  logic [DATA_W-1:0]      rem_q;

  // Working registers.
  logic [DATA_W-1:0]      elapsed_q;
  logic [DATA_W-1:0]      prod_q;
  logic [ACC_W-1:0]       acc_q;
  logic [DATA_W-1:0]      div_r_q;
  logic [DATA_W-1:0]      div_q_q;
  logic [DIV_CNT_W-1:0]   div_cnt_q;
  logic [COUNT_WIDTH-1:0] sum_q;
  logic [DATA_W-1:0]      res_data_q;
  logic                   res_irq_q;
  logic [DATA_W-1:0]      out_data_q;
  logic                   out_irq_q;

  logic [DATA_W-1:0]      elapsed;
  logic [DATA_W-1:0]      read_mux;
  logic [DATA_W:0]        div_shift;
  logic                   div_ge;
  logic [DATA_W:0]        div_diff;
  logic                   match;

  assign elapsed   = htime_q - last_q;
  assign div_shift = {div_r_q, acc_q[ACC_W-1]};
  assign div_diff  = div_shift - {1'b0, hfreq_i};
  assign div_ge    = div_shift >= {1'b0, hfreq_i};
  assign match     = (count_q < compare_q) && (sum_q >= compare_q);

  assign status_o.tick_go  = (mode_e'(mode_q) == MODE_TICK) && ctrl_q[CTRL_ENABLE]
                             && (elapsed != '0) && (hfreq_i != '0);
  assign status_o.div_last = (div_cnt_q == '0);

  always_comb begin
    case (sel_q)
      REG_CTRL:    read_mux = {{(DATA_W-CTRL_W){1'b0}}, ctrl_q};
      REG_COUNT:   read_mux = DATA_W'(count_q);
      REG_COMPARE: read_mux = DATA_W'(compare_q);
      REG_STATUS:  read_mux = {{(DATA_W-1){1'b0}}, irq_status_q};
      REG_FREQ:    read_mux = {{(DATA_W-VFREQ_W){1'b0}}, vfreq_i};
      default:     read_mux = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q       <= '0;
      count_q      <= '0;
      compare_q    <= '1;
      irq_status_q <= 1'b0;
      last_q       <= '0;
      rem_q        <= '0;
    end else begin
      if (cmd_i.decode) begin
        case (mode_e'(mode_q))
          MODE_TICK: begin
            last_q <= htime_q;
          end
          MODE_WRITE: begin
            case (sel_q)
              REG_CTRL: begin
                ctrl_q <= wval_q[CTRL_W-1:0];
                if (wval_q[CTRL_ENABLE]) begin
                  last_q <= htime_q;
                end
              end
              REG_COUNT:   count_q <= wval_q[COUNT_WIDTH-1:0];
              REG_COMPARE: compare_q <= wval_q[COUNT_WIDTH-1:0];
              REG_STATUS:  irq_status_q <= irq_status_q & ~wval_q[0];
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      if (cmd_i.add) begin
        rem_q <= div_r_q;
      end
      if (cmd_i.upd) begin
        if (match) begin
          irq_status_q <= 1'b1;
          if (ctrl_q[CTRL_PERIODIC]) begin
            count_q <= sum_q - compare_q;
          end else begin
            count_q               <= sum_q;
            ctrl_q[CTRL_ENABLE] <= 1'b0;
          end
        end else begin
          count_q <= sum_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q  <= mode_i;
      sel_q   <= reg_select_i;
      wval_q  <= write_value_i;
      htime_q <= host_time_i;
    end
    if (cmd_i.decode) begin
      elapsed_q  <= elapsed;
      res_data_q <= (mode_e'(mode_q) == MODE_READ) ? read_mux : '0;
      res_irq_q  <= 1'b0;
    end
    if (cmd_i.mul0) begin
      prod_q <= DATA_W'(elapsed_q[HALF_W-1:0]) * DATA_W'(vfreq_i);
    end
    if (cmd_i.mul1) begin
      prod_q <= DATA_W'(elapsed_q[DATA_W-1:HALF_W]) * DATA_W'(vfreq_i);
      acc_q  <= ACC_W'(rem_q) + ACC_W'(prod_q);
    end
    if (cmd_i.acc) begin
      acc_q     <= acc_q + {prod_q, {HALF_W{1'b0}}};
      div_r_q   <= '0;
      div_q_q   <= '0;
      div_cnt_q <= DIV_CNT_W'(ACC_W - 1);
    end
    if (cmd_i.div_step) begin
      acc_q     <= {acc_q[ACC_W-2:0], 1'b0};
      div_r_q   <= div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
      div_q_q   <= {div_q_q[DATA_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q - 1'b1;
    end
    if (cmd_i.add) begin
      sum_q <= count_q + div_q_q[COUNT_WIDTH-1:0];
    end
    if (cmd_i.upd) begin
      res_irq_q <= match && ctrl_q[CTRL_IRQ_EN];
    end
    if (cmd_i.load_out) begin
      out_data_q <= res_data_q;
      out_irq_q  <= res_irq_q;
    end
  end

  assign read_data_o = out_data_q;
  assign irq_raise_o = out_irq_q;

endmodule

`default_nettype wire

// ----- rtl/compare_match_timer.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer
// Timer with a fractional rate divider behind a small register file.
// ----------------------------------------------------------------------------
// Items arrive on in_item: a tick with a host timestamp, a register read or a
// register write. Every item yields exactly one transaction on out_res, with
// the read value for reads and the interrupt request flag for ticks.
// The host and virtual frequencies are set through the APB-style port, which
// must only be written while the block is idle.
// Reads, writes and ticks that do not advance the timer go from decode
// straight to the output. A tick that advances the timer also runs the
// two-step 64-by-32 multiply, the 96 iterations of the radix-2 divider and
// the count update. One item is processed at a time; the next one is taken
// as soon as the result has entered the output register.
// Reset clears the control, count, status and remainder state, sets compare
// to all ones and the frequencies to their defaults.
// When the receiver stalls, the result waits in the output register, and a
// further finished result waits in the block until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_match_timer
  import cmt_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  cmt_item_if.sink                in_item,
  cmt_result_if.source            out_res,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]  pwdata,
  output logic      [DATA_W-1:0]  prdata,
  output logic                    pready
);

  logic [DATA_W-1:0]  hfreq;
  logic [VFREQ_W-1:0] vfreq;
  cmd_t               cmd;
  status_t            status;

  cmt_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hfreq_o (hfreq),
    .vfreq_o (vfreq)
  );

  cmt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_item.valid),
    .in_ready_o  (in_item.ready),
    .out_valid_o (out_res.valid),
    .out_ready_i (out_res.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cmt_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .mode_i        (in_item.mode),
    .reg_select_i  (in_item.reg_select),
    .write_value_i (in_item.write_value),
    .host_time_i   (in_item.host_time),
    .hfreq_i       (hfreq),
    .vfreq_i       (vfreq),
    .read_data_o   (out_res.read_data),
    .irq_raise_o   (out_res.irq_raise)
  );

endmodule

`default_nettype wire

// ----- rtl/compare_match_timer_chk.sv -----
// ----------------------------------------------------------------------------
// Compare-match timer checker
// Port-level assertions on the item and result channels, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module compare_match_timer_chk
  import cmt_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] read_data,
  input wire logic              irq_raise
);

  // A pending result transaction holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(irq_raise))
    else $error("result transaction changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("item accepted while the previous one is in progress");

  // An interrupt request only comes with a tick, whose data is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && irq_raise |-> read_data == '0)
    else $error("interrupt request with non-zero read data");

  // A result cannot appear in the cycle right after an item is accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind compare_match_timer compare_match_timer_chk u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_item.valid),
  .in_ready  (in_item.ready),
  .out_valid (out_res.valid),
  .out_ready (out_res.ready),
  .read_data (out_res.read_data),
  .irq_raise (out_res.irq_raise)
);

`default_nettype wire
